/* hw/rtl/knnmd_pkg.sv */
// knnmd_pkg: shared types and constants of the k-nearest-neighbour radius block
`default_nettype none
package knnmd_pkg;

  localparam int COORD_W  = 32;   // Q15.16 coordinate
  localparam int DIST_W   = 33;   // Q17.16 distance
  localparam int DIV_W    = 40;   // divider dividend / radius sum width
  localparam int DVSR_W   = 7;    // divider divisor width
  localparam int SCALE_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOURS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd2;

  localparam logic [1:0]         DIM_RESET   = 2'd3;
  localparam logic [4:0]         NEIGH_RESET = 5'd3;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;
  localparam logic [6:0]         DEF_NEIGH   = 7'd3;

  typedef struct packed {
    logic       mem_we;
    logic       mem_re;
    logic       latch_a;
    logic       acc_clr;
    logic       diff_go;
    logic       sq_go;
    logic       acc_add;
    logic       sqrt_go;
    logic       ins_go;
    logic       list_clr;
    logic       sum_step;
    logic       div_avg;
    logic       div_mean;
    logic       scale_go;
    logic       sat_go;
    logic       rad_zero;
    logic       rsum_clr;
    logic       out_ld;
    logic       out_last;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/knnmd_in_if.sv */
// knnmd_in_if: node coordinate channel
`default_nettype none
interface knnmd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;
  logic        last_node;

  modport source (output valid, coord_x, coord_y, coord_z, last_node, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_node, output ready);
endinterface
`default_nettype wire

/* hw/rtl/knnmd_out_if.sv */
// knnmd_out_if: radius result channel
`default_nettype none
interface knnmd_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  node_index;
  logic [31:0] radius;
  logic [31:0] mean_radius;
  logic        last_result;

  modport source (output valid, node_index, radius, mean_radius, last_result, input ready);
  modport sink   (input valid, node_index, radius, mean_radius, last_result, output ready);
endinterface
`default_nettype wire

/* hw/rtl/knnmd_dp.sv */
// knnmd_dp: node store, distance, square root, neighbour list, divider and output registers
`default_nettype none
module knnmd_dp #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_NEIGHBOURS = 16,
  parameter int NW = $clog2(MAX_NODES),
  parameter int CW = $clog2(MAX_NODES + 1),
  parameter int KW = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  knnmd_pkg::cmd_t     cmd,
  output knnmd_pkg::sts_t     sts,
  input  wire [NW-1:0]        wr_addr,
  input  wire [NW-1:0]        rd_addr,
  input  wire [NW-1:0]        node_j,
  input  wire [KW-1:0]        k,
  input  wire [CW-1:0]        n,
  input  wire [15:0]          scale_factor,
  input  wire [31:0]          coord_x,
  input  wire [31:0]          coord_y,
  input  wire [31:0]          coord_z,
  output logic [5:0]          node_index,
  output logic [31:0]         radius,
  output logic [31:0]         mean_radius,
  output logic                last_result
);
  localparam int DW  = knnmd_pkg::DIST_W;
  localparam int SDW = DW + KW;

  logic [95:0]        mem [MAX_NODES];
  logic [95:0]        rdata_r;
  logic [95:0]        a_r;
  logic [DW-1:0]      diff_r;
  logic [65:0]        sq_r;
  logic [67:0]        acc_r;

  // square root unit
  logic [67:0]        val_r;
  logic [35:0]        rem_r;
  logic [33:0]        root_r;
  logic [5:0]         sq_cnt_r;
  logic [37:0]        remw, trial;
  logic               ge;
  logic [DW-1:0]      root_dist;

  logic [DW-1:0]      list_r [MAX_NEIGHBOURS];
  logic [DW-1:0]      prv    [MAX_NEIGHBOURS];
  logic [DW-1:0]      ins    [MAX_NEIGHBOURS];
  logic [SDW-1:0]     dsum_r;

  // divider
  logic [knnmd_pkg::DIV_W-1:0]  q_r;
  logic [knnmd_pkg::DVSR_W-1:0] r_r, dvs_r;
  logic [knnmd_pkg::DVSR_W:0]   rs;
  logic                         dge;
  logic [5:0]                   dv_cnt_r;

  logic [48:0]        prod_r;
  logic [31:0]        rad_r, rad_sat;
  logic [knnmd_pkg::DIV_W-1:0] rsum_r;

  logic signed [31:0] ca, cb;
  logic signed [DW-1:0] d;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[wr_addr] <= {coord_z, coord_y, coord_x};
    end
    if (cmd.mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    ca = a_r[cmd.axis*32 +: 32];
    cb = rdata_r[cmd.axis*32 +: 32];
    d  = DW'(ca) - DW'(cb);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      a_r <= rdata_r;
    end
    if (cmd.diff_go) begin
      diff_r <= d[DW-1] ? DW'(-d) : DW'(d);
    end
    if (cmd.sq_go) begin
      sq_r <= 66'(diff_r) * 66'(diff_r);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + 68'(sq_r);
    end
  end

  // one result bit per step, top pair first
  always_comb begin
    remw      = {rem_r, val_r[67:66]};
    trial     = {2'b00, root_r, 2'b01};
    ge        = remw >= trial;
    root_dist = root_r[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_cnt_r <= '0;
    end else if (cmd.sqrt_go) begin
      sq_cnt_r <= 6'd34;
    end else if (sq_cnt_r != '0) begin
      sq_cnt_r <= sq_cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_go) begin
      val_r  <= acc_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (sq_cnt_r != '0) begin
      val_r  <= {val_r[65:0], 2'b00};
      rem_r  <= ge ? 36'(remw - trial) : remw[35:0];
      root_r <= {root_r[32:0], ge};
    end
  end

  // sorted insert, ascending; entries from k up stay empty
  always_comb begin
    prv[0] = root_dist;
    for (int m = 1; m < MAX_NEIGHBOURS; m++) begin
      prv[m] = (list_r[m-1] <= root_dist) ? root_dist : list_r[m-1];
    end
    for (int m = 0; m < MAX_NEIGHBOURS; m++) begin
      ins[m] = (KW'(m) < k && list_r[m] > root_dist) ? prv[m] : list_r[m];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.list_clr) begin
      for (int m = 0; m < MAX_NEIGHBOURS; m++) begin
        list_r[m] <= '1;
      end
      dsum_r <= '0;
    end else if (cmd.ins_go) begin
      for (int m = 0; m < MAX_NEIGHBOURS; m++) begin
        list_r[m] <= ins[m];
      end
    end else if (cmd.sum_step) begin
      dsum_r <= dsum_r + SDW'(list_r[0]);
      for (int m = 0; m < MAX_NEIGHBOURS - 1; m++) begin
        list_r[m] <= list_r[m+1];
      end
      list_r[MAX_NEIGHBOURS-1] <= '1;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rs  = {r_r, q_r[knnmd_pkg::DIV_W-1]};
    dge = rs >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_cnt_r <= '0;
    end else if (cmd.div_avg || cmd.div_mean) begin
      dv_cnt_r <= 6'(knnmd_pkg::DIV_W);
    end else if (dv_cnt_r != '0) begin
      dv_cnt_r <= dv_cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_avg) begin
      q_r   <= knnmd_pkg::DIV_W'(dsum_r);
      r_r   <= '0;
      dvs_r <= knnmd_pkg::DVSR_W'(k);
    end else if (cmd.div_mean) begin
      q_r   <= rsum_r;
      r_r   <= '0;
      dvs_r <= knnmd_pkg::DVSR_W'(n);
    end else if (dv_cnt_r != '0) begin
      q_r <= {q_r[knnmd_pkg::DIV_W-2:0], dge};
      r_r <= dge ? knnmd_pkg::DVSR_W'(rs - {1'b0, dvs_r}) : rs[knnmd_pkg::DVSR_W-1:0];
    end
  end

  assign rad_sat = (prod_r[48:44] != '0) ? '1 : prod_r[43:12];

  always_ff @(posedge clk) begin
    if (cmd.scale_go) begin
      prod_r <= 49'(q_r[DW-1:0]) * 49'(scale_factor);
    end
    if (cmd.sat_go) begin
      rad_r <= cmd.rad_zero ? '0 : rad_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.rsum_clr) begin
      rsum_r <= '0;
    end else if (cmd.sat_go && !cmd.rad_zero) begin
      rsum_r <= rsum_r + knnmd_pkg::DIV_W'(rad_sat);
    end
  end

  // rad_r holds still from the end of its node's scaling until the beat is taken
  assign radius = rad_r;

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      node_index  <= 6'(node_j);
      mean_radius <= cmd.out_last ? q_r[31:0] : '0;
      last_result <= cmd.out_last;
    end
  end

  assign sts.sqrt_busy = sq_cnt_r != '0;
  assign sts.div_busy  = dv_cnt_r != '0;

endmodule
`default_nettype wire

/* hw/rtl/knnmd_ctrl.sv */
// knnmd_ctrl: sequencer over load, pair distance, list, average and output phases
`default_nettype none
module knnmd_ctrl #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_NEIGHBOURS = 16,
  parameter int MAX_DIM        = 3,
  parameter int NW = $clog2(MAX_NODES),
  parameter int CW = $clog2(MAX_NODES + 1),
  parameter int KW = $clog2(MAX_NEIGHBOURS + 1)
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  wire [1:0]        dimension,
  input  wire [4:0]        neighbour_count,
  output knnmd_pkg::cmd_t  cmd,
  input  knnmd_pkg::sts_t  sts,
  output logic [NW-1:0]    wr_addr,
  output logic [NW-1:0]    rd_addr,
  output logic [NW-1:0]    node_j,
  output logic [KW-1:0]    k,
  output logic [CW-1:0]    n
);
  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_SETUP = 5'd1;
  localparam logic [4:0] S_NODE  = 5'd2;
  localparam logic [4:0] S_LATJ  = 5'd3;
  localparam logic [4:0] S_PAIR  = 5'd4;
  localparam logic [4:0] S_LATI  = 5'd5;
  localparam logic [4:0] S_DIFF  = 5'd6;
  localparam logic [4:0] S_SQ    = 5'd7;
  localparam logic [4:0] S_ACC   = 5'd8;
  localparam logic [4:0] S_SQRT  = 5'd9;
  localparam logic [4:0] S_SQRTW = 5'd10;
  localparam logic [4:0] S_INS   = 5'd11;
  localparam logic [4:0] S_SUM   = 5'd12;
  localparam logic [4:0] S_DIVA  = 5'd13;
  localparam logic [4:0] S_DIVAW = 5'd14;
  localparam logic [4:0] S_SCALE = 5'd15;
  localparam logic [4:0] S_SAT   = 5'd16;
  localparam logic [4:0] S_DIVM  = 5'd17;
  localparam logic [4:0] S_DIVMW = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [NW-1:0] j_r, j_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [KW-1:0] k_r, k_nxt, m_r, m_nxt;
  logic [1:0]    ax_r, ax_nxt;
  logic [1:0]    axes;
  logic [6:0]    kt, kc, nm1;
  logic          is_last, room;

  always_comb begin
    axes = (dimension == 2'd0) ? 2'd1 : dimension;
    if (axes > 2'(MAX_DIM)) begin
      axes = 2'(MAX_DIM);
    end
    kt  = (neighbour_count == 5'd0) ? knnmd_pkg::DEF_NEIGH : 7'(neighbour_count);
    kc  = (kt > 7'(MAX_NEIGHBOURS)) ? 7'(MAX_NEIGHBOURS) : kt;
    nm1 = 7'(n_r) - 7'd1;
    if (kc > nm1) begin
      kc = nm1;
    end
  end

  assign is_last = CW'(j_r) == n_r - CW'(1);
  assign room    = n_r < CW'(MAX_NODES);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    ax_nxt    = ax_r;
    cmd       = '0;
    cmd.axis  = ax_r;
    cmd.rad_zero = k_r == '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.mem_we = room;
          if (room) begin
            n_nxt = n_r + CW'(1);
          end
          if (in_last) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        k_nxt        = KW'(kc);
        j_nxt        = '0;
        cmd.rsum_clr = 1'b1;
        state_nxt    = S_NODE;
      end
      S_NODE: begin
        cmd.list_clr = 1'b1;
        m_nxt        = '0;
        if (k_r == '0) begin
          state_nxt = S_SAT;
        end else begin
          cmd.mem_re = 1'b1;
          state_nxt  = S_LATJ;
        end
      end
      S_LATJ: begin
        cmd.latch_a = 1'b1;
        i_nxt       = '0;
        state_nxt   = S_PAIR;
      end
      S_PAIR: begin
        priority if (i_r == n_r) begin
          state_nxt = S_SUM;
        end else if (i_r == CW'(j_r)) begin
          i_nxt = i_r + CW'(1);
        end else begin
          cmd.mem_re = 1'b1;
          state_nxt  = S_LATI;
        end
      end
      S_LATI: begin
        cmd.acc_clr = 1'b1;
        ax_nxt      = '0;
        state_nxt   = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_go = 1'b1;
        state_nxt   = S_SQ;
      end
      S_SQ: begin
        cmd.sq_go = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        if (ax_r == axes - 2'd1) begin
          state_nxt = S_SQRT;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_DIFF;
        end
      end
      S_SQRT: begin
        cmd.sqrt_go = 1'b1;
        state_nxt   = S_SQRTW;
      end
      S_SQRTW: begin
        if (!sts.sqrt_busy) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins_go = 1'b1;
        i_nxt      = i_r + CW'(1);
        state_nxt  = S_PAIR;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        m_nxt        = m_r + KW'(1);
        if (m_r == k_r - KW'(1)) begin
          state_nxt = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd.div_avg = 1'b1;
        state_nxt   = S_DIVAW;
      end
      S_DIVAW: begin
        if (!sts.div_busy) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale_go = 1'b1;
        state_nxt    = S_SAT;
      end
      S_SAT: begin
        cmd.sat_go = 1'b1;
        state_nxt  = is_last ? S_DIVM : S_OUT;
        cmd.out_ld = !is_last;
      end
      S_DIVM: begin
        cmd.div_mean = 1'b1;
        state_nxt    = S_DIVMW;
      end
      S_DIVMW: begin
        if (!sts.div_busy) begin
          cmd.out_ld   = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (is_last) begin
            n_nxt     = '0;
            state_nxt = S_LOAD;
          end else begin
            j_nxt     = j_r + NW'(1);
            state_nxt = S_NODE;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      n_r     <= '0;
      j_r     <= '0;
      i_r     <= '0;
      k_r     <= '0;
      m_r     <= '0;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      j_r     <= j_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      m_r     <= m_nxt;
      ax_r    <= ax_nxt;
    end
  end

  assign wr_addr = n_r[NW-1:0];
  assign rd_addr = (state_r == S_NODE) ? j_r : i_r[NW-1:0];
  assign node_j  = j_r;
  assign k       = k_r;
  assign n       = n_r;

  a_k_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && state_r != S_SETUP) |-> (7'(k_r) < 7'(n_r)))
    else $error("neighbour count not below node count");
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(MAX_NODES))
    else $error("node count beyond store depth");
  a_set_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_ready && is_last) |=> (state_r == S_LOAD && n_r == '0))
    else $error("store not emptied after final result");
  a_sqrt_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_go |=> sts.sqrt_busy)
    else $error("square root unit did not start");

endmodule
`default_nettype wire

/* hw/rtl/knn_mean_distance_radius_top.sv */
// knn_mean_distance_radius_top: k-nearest-neighbour mean distance radius, top level
// Load: one node beat per cycle; in_ch.ready is high only while loading.
// After the last node: per node j, (n-1) pair passes, each dominated by the square root,
//   then the list sum, divide and scaling; the final node adds a further divide for the
//   mean.
// One result beat per node, the next node starts once a beat is taken.
// Reset (rst_n low, synchronous): empty store, idle controller, registers to defaults.
`default_nettype none
module knn_mean_distance_radius_top #(
  parameter int MAX_NODES      = 64,
  parameter int MAX_NEIGHBOURS = 16,
  parameter int MAX_DIM        = 3
) (
  input  wire                                clk,
  input  wire                                rst_n,
  knnmd_in_if.sink                           in_ch,
  knnmd_out_if.source                        out_ch,
  input  wire                                cfg_we,
  input  wire [knnmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [knnmd_pkg::CFG_W-1:0]         cfg_data
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int KW = $clog2(MAX_NEIGHBOURS + 1);

  // configuration registers; the user writes them only while idle, the block does not enforce it
  logic [1:0]  dimension_r;
  logic [4:0]  neighbour_r;
  logic [15:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimension_r <= knnmd_pkg::DIM_RESET;
      neighbour_r <= knnmd_pkg::NEIGH_RESET;
      scale_r     <= knnmd_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        knnmd_pkg::CFG_DIMENSION:  dimension_r <= cfg_data[1:0];
        knnmd_pkg::CFG_NEIGHBOURS: neighbour_r <= cfg_data[4:0];
        knnmd_pkg::CFG_SCALE:      scale_r     <= cfg_data;
        default: ;  // unused index: write ignored
      endcase
    end
  end

  knnmd_pkg::cmd_t cmd;
  knnmd_pkg::sts_t sts;
  logic [NW-1:0]   wr_addr, rd_addr, node_j;
  logic [KW-1:0]   k;
  logic [CW-1:0]   n;

  // sequencer: owns node/pair/axis counters and the beat handshakes
  knnmd_ctrl #(
    .MAX_NODES(MAX_NODES), .MAX_NEIGHBOURS(MAX_NEIGHBOURS), .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_last(in_ch.last_node), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .dimension(dimension_r), .neighbour_count(neighbour_r),
    .cmd, .sts, .wr_addr, .rd_addr, .node_j, .k, .n
  );

  // datapath: node memory, distance, sqrt, sorted list, divider, result register
  knnmd_dp #(
    .MAX_NODES(MAX_NODES), .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .wr_addr, .rd_addr, .node_j, .k, .n,
    .scale_factor(scale_r),
    .coord_x(in_ch.coord_x), .coord_y(in_ch.coord_y), .coord_z(in_ch.coord_z),
    .node_index(out_ch.node_index), .radius(out_ch.radius),
    .mean_radius(out_ch.mean_radius), .last_result(out_ch.last_result)
  );

endmodule
`default_nettype wire

/* tb/tb.sv */
// tb: self-checking testbench of the k-nearest-neighbour mean distance radius block
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int NODE_CAP   = 64;
  localparam int NEIGH_CAP  = 16;
  localparam int HOLD_LEN   = 400;     // long receiver hold-off, cycles
  localparam int IDLE_LIMIT = 40000;   // cycles with no beat before giving up
  localparam int QUIET_LEN  = 60;      // settle time before register writes
  localparam logic [63:0] NO_DIST = 64'h1_FFFF_FFFF;

  typedef struct packed {
    logic [5:0]  node_index;
    logic [31:0] radius;
    logic [31:0] mean_radius;
    logic        last_result;
  } radius_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [knnmd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [knnmd_pkg::CFG_W-1:0]     cfg_data;

  knnmd_in_if  in_ch ();
  knnmd_out_if out_ch ();

  knn_mean_distance_radius_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: registers and node store
  logic [1:0]  dim_q;
  logic [4:0]  neigh_q;
  logic [15:0] scale_q;
  longint      node_mem [NODE_CAP][3];
  int          node_cnt;

  radius_beat_t radius_q[$];   // radii still owed by the block
  int  errors;
  int  items_sent;
  int  sets_done;
  int  beats_seen;
  bit  hold_req;               // asks the receiver for a long hold-off
  bit  burst;                  // no idling on either side while set
  int  idle_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] floor_sqrt(logic [67:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    rem  = '0;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem   = (rem << 2) | 64'(v[2*i +: 2]);
      trial = (root << 2) | 64'd1;
      root  = root << 1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] pair_distance(int a, int b, int axes);
    logic [67:0] acc;
    longint      d;
    logic [63:0] mag;
    acc = '0;
    for (int ax = 0; ax < axes; ax++) begin
      d   = node_mem[a][ax] - node_mem[b][ax];
      mag = (d < 0) ? 64'(-d) : 64'(d);
      acc = acc + 68'(mag * mag);
    end
    return floor_sqrt(acc);
  endfunction

  // radius per stored node, queued in node order; store then emptied
  task automatic predict_radii();
    int           n;
    int           k;
    int           axes;
    int           m;
    logic [63:0]  closest [NEIGH_CAP];
    logic [63:0]  d;
    logic [63:0]  dsum;
    logic [63:0]  scaled;
    logic [39:0]  rsum;
    radius_beat_t b;
    n    = node_cnt;
    axes = (dim_q == 2'd0) ? 1 : int'(dim_q);
    k    = (neigh_q == 5'd0) ? int'(knnmd_pkg::DEF_NEIGH) : int'(neigh_q);
    if (k > NEIGH_CAP) k = NEIGH_CAP;
    if (k > n - 1) k = n - 1;
    rsum = '0;
    for (int j = 0; j < n; j++) begin
      b = '0;
      b.node_index = 6'(j);
      for (int q = 0; q < NEIGH_CAP; q++) closest[q] = NO_DIST;
      if (k > 0) begin
        for (int i = 0; i < n; i++) begin
          if (i != j) begin
            d = pair_distance(j, i, axes);
            if (d < closest[k-1]) begin
              m = k - 1;
              while (m > 0 && closest[m-1] > d) begin
                closest[m] = closest[m-1];
                m--;
              end
              closest[m] = d;
            end
          end
        end
        dsum = '0;
        for (int q = 0; q < k; q++) dsum += closest[q];
        scaled = ((dsum / 64'(k)) * 64'(scale_q)) >> 12;
        b.radius = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
      end
      rsum = rsum + 40'(b.radius);
      if (j == n - 1) begin
        b.mean_radius = 32'(rsum / 40'(n));
        b.last_result = 1'b1;
      end
      radius_q = {radius_q, b};
    end
    node_cnt = 0;
  endtask

  task automatic store_node(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    if (node_cnt < NODE_CAP) begin
      node_mem[node_cnt][0] = longint'($signed(x));
      node_mem[node_cnt][1] = longint'($signed(y));
      node_mem[node_cnt][2] = longint'($signed(z));
      node_cnt++;
    end
    if (last) predict_radii();
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // one node beat; valid stays high afterwards so back-to-back beats need no gap
  task automatic send_node(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.coord_x   <= x;
    in_ch.coord_y   <= y;
    in_ch.coord_z   <= z;
    in_ch.last_node <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    items_sent++;
    store_node(x, y, z, last);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // block idle: every radius in, then a settle pause
  task automatic wait_drained();
    drop_valid();
    while (radius_q.size() != 0) @(posedge clk);
    repeat (QUIET_LEN) @(posedge clk);
  endtask

  task automatic write_reg(logic [knnmd_pkg::CFG_IDX_W-1:0] idx,
                           logic [knnmd_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      knnmd_pkg::CFG_DIMENSION:  dim_q   = val[1:0];
      knnmd_pkg::CFG_NEIGHBOURS: neigh_q = val[4:0];
      knnmd_pkg::CFG_SCALE:      scale_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [1:0] dim, logic [4:0] neigh, logic [15:0] scale);
    wait_drained();
    write_reg(knnmd_pkg::CFG_DIMENSION, knnmd_pkg::CFG_W'(dim));
    write_reg(knnmd_pkg::CFG_NEIGHBOURS, knnmd_pkg::CFG_W'(neigh));
    write_reg(knnmd_pkg::CFG_SCALE, scale);
  endtask

  // mostly moderate values so distances vary, some full range, some extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom();
      4:       return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++)
      send_node(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  task automatic report(string what, longint got, longint want);
    $display("mismatch beat %0d %s: got %0h expected %0h", beats_seen, what, got, want);
    errors++;
  endtask

  task automatic check_beat();
    radius_beat_t want;
    beats_seen++;
    if (radius_q.size() == 0) begin
      $display("unexpected radius beat, node %0d", out_ch.node_index);
      errors++;
    end else begin
      want = radius_q.pop_front();
      if (out_ch.node_index !== want.node_index)
        report("node_index", out_ch.node_index, want.node_index);
      if (out_ch.radius !== want.radius)
        report("radius", out_ch.radius, want.radius);
      if (out_ch.mean_radius !== want.mean_radius)
        report("mean_radius", out_ch.mean_radius, want.mean_radius);
      if (out_ch.last_result !== want.last_result)
        report("last_result", out_ch.last_result, want.last_result);
    end
  endtask

  initial begin : receiver
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills and stalls its input
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = draw_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && !hold_req);
      if (out_ch.valid && out_ch.ready) check_beat();
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d radii pending",
               idle_cycles, radius_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // defaults after reset, coordinate extremes
  task automatic test_reset_defaults();
    send_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_node(32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
    send_node(32'hFFFF_0000, 32'h0000_0001, 32'h8000_0001, 1'b1);
  endtask

  // lone node: no neighbours, radius and mean both zero
  task automatic test_single_node();
    send_node(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b1);
  endtask

  // equal distances and coincident nodes
  task automatic test_ties();
    send_node(32'h0001_0000, 32'h0000_0000, 32'h0, 1'b0);
    send_node(32'hFFFF_0000, 32'h0000_0000, 32'h0, 1'b0);
    send_node(32'h0000_0000, 32'h0001_0000, 32'h0, 1'b0);
    send_node(32'h0000_0000, 32'hFFFF_0000, 32'h0, 1'b0);
    send_node(32'h0000_0000, 32'h0001_0000, 32'h0, 1'b1);
  endtask

  // register sweep: zero dimension, default and oversize counts, scale extremes
  task automatic test_config_sweep();
    set_config(2'd0, 5'd0, 16'd4096);
    send_random_set(4);
    set_config(2'd1, 5'd1, 16'hFFFF);
    send_random_set(3);
    set_config(2'd2, 5'd16, 16'd0);
    send_random_set(3);
    set_config(2'd3, 5'd31, 16'hFFFF);
    send_node(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    set_config(2'd3, 5'd17, 16'd1);
    send_random_set(4);
  endtask

  // more nodes than the store holds; the dropped last beat still starts the pass
  task automatic test_store_full();
    set_config(2'd3, 5'd16, 16'hFFFF);
    burst = 1'b1;
    for (int i = 0; i < NODE_CAP + 2; i++)
      send_node($urandom(), $urandom(), $urandom(), i == NODE_CAP + 1);
    burst = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering the next set
  task automatic test_backpressure();
    set_config(2'd2, 5'd2, 16'd8192);
    hold_req = 1'b1;
    send_random_set(6);
    send_random_set(4);
  endtask

  task automatic test_random(int budget);
    int n;
    while (items_sent < budget) begin
      if ($urandom_range(0, 3) == 0)
        set_config(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                   16'($urandom()));
      burst = ($urandom_range(0, 5) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_random_set(n);
      sets_done++;
    end
    burst = 1'b0;
  endtask

  initial begin : main
    in_ch.valid     <= 1'b0;
    in_ch.coord_x   <= '0;
    in_ch.coord_y   <= '0;
    in_ch.coord_z   <= '0;
    in_ch.last_node <= 1'b0;
    out_ch.ready    <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    rst_n           <= 1'b0;
    dim_q    = knnmd_pkg::DIM_RESET;
    neigh_q  = knnmd_pkg::NEIGH_RESET;
    scale_q  = knnmd_pkg::SCALE_RESET;
    node_cnt = 0;
    errors = 0; items_sent = 0; sets_done = 0; beats_seen = 0;
    hold_req = 1'b0; burst = 1'b0; idle_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_single_node();
    test_ties();
    test_config_sweep();
    test_store_full();
    test_backpressure();
    test_random(460);

    drop_valid();
    while (radius_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d node beats in %0d random sets plus directed sets,",
             items_sent, sets_done);
    $display("checked %0d radius beats across dimension, count and scale settings",
             beats_seen);
    if (errors == 0 && radius_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/knnmd_pkg.sv
hw/rtl/knnmd_in_if.sv
hw/rtl/knnmd_out_if.sv
hw/rtl/knnmd_dp.sv
hw/rtl/knnmd_ctrl.sv
hw/rtl/knn_mean_distance_radius_top.sv
tb/tb.sv
